FILE: design/pp2p_pkg.sv
package pp2p_pkg;

    localparam int GUARD_BITS   = 24;
    localparam int ANGLE_BITS   = 28;
    localparam int ATAN_BITS    = 27;
    localparam int BEARING_BITS = 16;
    localparam int SEP_BITS     = 25;
    localparam int SQ_BITS      = 50;
    localparam int ROOT_BITS    = 52;
    localparam int ROOT_STEPS   = 26;
    localparam int OUT_BITS     = 48;
    localparam int ROUND_SHIFT  = 11;
    localparam int ROUND_HALF   = 1024;
    localparam int PI_Q24       = 52707180;
    localparam int PI_Q13       = 25736;
    localparam int HALF_PI_Q13  = 12868;

    localparam logic [SEP_BITS-1:0] SEP_MAX = '1;

    typedef struct packed {
        logic                    special;
        logic [BEARING_BITS-1:0] special_bearing;
        logic                    big;
    } flags_t;

    // arctangent of 2^-idx in radians, 24 fraction bits
    function automatic logic [ATAN_BITS-1:0] atan_q24(input logic [4:0] idx);
        logic [ATAN_BITS-1:0] a;
        case (idx)
            5'd0:    a = 27'd13176795;
            5'd1:    a = 27'd7778716;
            5'd2:    a = 27'd4110060;
            5'd3:    a = 27'd2086331;
            5'd4:    a = 27'd1047214;
            5'd5:    a = 27'd524117;
            5'd6:    a = 27'd262123;
            5'd7:    a = 27'd131069;
            5'd8:    a = 27'd65536;
            5'd9:    a = 27'd32768;
            5'd10:   a = 27'd16384;
            5'd11:   a = 27'd8192;
            5'd12:   a = 27'd4096;
            5'd13:   a = 27'd2048;
            5'd14:   a = 27'd1024;
            5'd15:   a = 27'd512;
            5'd16:   a = 27'd256;
            5'd17:   a = 27'd128;
            5'd18:   a = 27'd64;
            5'd19:   a = 27'd32;
            5'd20:   a = 27'd16;
            5'd21:   a = 27'd8;
            5'd22:   a = 27'd4;
            5'd23:   a = 27'd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

FILE: design/pp2p_prep.sv
module pp2p_prep #(
    parameter int COORD_BITS = 24
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  valid_in,
    output logic                                  ready_out,
    input  logic signed [COORD_BITS-1:0]          from_x,
    input  logic signed [COORD_BITS-1:0]          from_y,
    input  logic signed [COORD_BITS-1:0]          to_x,
    input  logic signed [COORD_BITS-1:0]          to_y,
    output logic                                  valid_out,
    input  logic                                  ready_in,
    output logic signed [COORD_BITS+pp2p_pkg::GUARD_BITS+2:0] x_out,
    output logic signed [COORD_BITS+pp2p_pkg::GUARD_BITS+2:0] y_out,
    output logic signed [pp2p_pkg::ANGLE_BITS-1:0] z_out,
    output logic [pp2p_pkg::ROOT_BITS-1:0]        n_out,
    output pp2p_pkg::flags_t                      flags_out
);

    localparam int D  = COORD_BITS + 1;
    localparam int XW = COORD_BITS + pp2p_pkg::GUARD_BITS + 3;
    localparam int EW = (COORD_BITS > pp2p_pkg::SEP_BITS) ? COORD_BITS : pp2p_pkg::SEP_BITS;
    localparam int SB = pp2p_pkg::SEP_BITS;
    localparam int BB = pp2p_pkg::BEARING_BITS;
    localparam int ZW = pp2p_pkg::ANGLE_BITS;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    // stage 1: difference vector
    logic signed [D-1:0] dx_reg, dy_reg, dx_next, dy_next;

    // stage 2: magnitudes, half-plane pre-rotation, special cases
    logic signed [D-1:0] ax_full, ay_full, y0;
    logic [EW-1:0] ax_e, ay_e;
    logic dx_zero, dy_zero, dx_neg, dy_neg, dy_pos, big;
    logic signed [XW-1:0] x2_reg, y2_reg, x2_next, y2_next;
    logic signed [ZW-1:0] z2_reg, z2_next;
    logic [SB-1:0] axc2_reg, ayc2_reg, axc2_next, ayc2_next;
    pp2p_pkg::flags_t f2_reg, f2_next;

    // stage 3: squares
    logic signed [XW-1:0] x3_reg, y3_reg;
    logic signed [ZW-1:0] z3_reg;
    logic [pp2p_pkg::SQ_BITS-1:0] sqx3_reg, sqy3_reg, sqx3_next, sqy3_next;
    pp2p_pkg::flags_t f3_reg;

    // stage 4: sum of squares
    logic signed [XW-1:0] x4_reg, y4_reg;
    logic signed [ZW-1:0] z4_reg;
    logic [pp2p_pkg::ROOT_BITS-1:0] n4_reg, n4_next;
    pp2p_pkg::flags_t f4_reg;

    assign rdy4 = !v4_reg || ready_in;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign ready_out = rdy1;

    assign dx_next = {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
    assign dy_next = {to_y[COORD_BITS-1], to_y} - {from_y[COORD_BITS-1], from_y};

    always_comb
    begin
        dx_zero = (dx_reg == '0);
        dy_zero = (dy_reg == '0);
        dx_neg  = dx_reg[D-1];
        dy_neg  = dy_reg[D-1];
        dy_pos  = !dy_neg && !dy_zero;
        ax_full = dx_neg ? -dx_reg : dx_reg;
        ay_full = dy_neg ? -dy_reg : dy_reg;
        y0      = dx_neg ? -dy_reg : dy_reg;

        x2_next = XW'($unsigned(ax_full)) << pp2p_pkg::GUARD_BITS;
        y2_next = XW'(y0) <<< pp2p_pkg::GUARD_BITS;
        if (dx_neg)
            z2_next = dy_pos ? ZW'(pp2p_pkg::PI_Q24) : ZW'(-pp2p_pkg::PI_Q24);
        else
            z2_next = '0;

        ax_e = EW'(ax_full[COORD_BITS-1:0]);
        ay_e = EW'(ay_full[COORD_BITS-1:0]);
        big  = (ax_e > EW'(pp2p_pkg::SEP_MAX)) || (ay_e > EW'(pp2p_pkg::SEP_MAX));
        axc2_next = big ? '0 : ax_e[SB-1:0];
        ayc2_next = big ? '0 : ay_e[SB-1:0];

        f2_next.big     = big;
        f2_next.special = dx_zero || dy_zero;
        if (dx_zero)
        begin
            if (dy_pos)
                f2_next.special_bearing = BB'(pp2p_pkg::HALF_PI_Q13);
            else if (dy_neg)
                f2_next.special_bearing = BB'(-pp2p_pkg::HALF_PI_Q13);
            else
                f2_next.special_bearing = '0;
        end
        else
        begin
            f2_next.special_bearing = dx_neg ? BB'(pp2p_pkg::PI_Q13) : '0;
        end
    end

    assign sqx3_next = {{SB{1'b0}}, axc2_reg} * {{SB{1'b0}}, axc2_reg};
    assign sqy3_next = {{SB{1'b0}}, ayc2_reg} * {{SB{1'b0}}, ayc2_reg};
    assign n4_next   = {2'b00, sqx3_reg} + {2'b00, sqy3_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= valid_in;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
        end
        if (rdy2)
        begin
            x2_reg   <= x2_next;
            y2_reg   <= y2_next;
            z2_reg   <= z2_next;
            axc2_reg <= axc2_next;
            ayc2_reg <= ayc2_next;
            f2_reg   <= f2_next;
        end
        if (rdy3)
        begin
            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            z3_reg   <= z2_reg;
            sqx3_reg <= sqx3_next;
            sqy3_reg <= sqy3_next;
            f3_reg   <= f2_reg;
        end
        if (rdy4)
        begin
            x4_reg <= x3_reg;
            y4_reg <= y3_reg;
            z4_reg <= z3_reg;
            n4_reg <= n4_next;
            f4_reg <= f3_reg;
        end
    end

    assign valid_out = v4_reg;
    assign x_out     = x4_reg;
    assign y_out     = y4_reg;
    assign z_out     = z4_reg;
    assign n_out     = n4_reg;
    assign flags_out = f4_reg;

endmodule

FILE: design/pp2p_cell.sv
module pp2p_cell #(
    parameter int XW             = 51,
    parameter int STEP           = 0,
    parameter int ROTATION_STEPS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid_in,
    output logic                                   ready_out,
    input  logic signed [XW-1:0]                   x_in,
    input  logic signed [XW-1:0]                   y_in,
    input  logic signed [pp2p_pkg::ANGLE_BITS-1:0] z_in,
    input  logic [pp2p_pkg::ROOT_BITS-1:0]         rem_in,
    input  logic [pp2p_pkg::ROOT_BITS-1:0]         res_in,
    input  pp2p_pkg::flags_t                       flags_in,
    output logic                                   valid_out,
    input  logic                                   ready_in,
    output logic signed [XW-1:0]                   x_out,
    output logic signed [XW-1:0]                   y_out,
    output logic signed [pp2p_pkg::ANGLE_BITS-1:0] z_out,
    output logic [pp2p_pkg::ROOT_BITS-1:0]         rem_out,
    output logic [pp2p_pkg::ROOT_BITS-1:0]         res_out,
    output pp2p_pkg::flags_t                       flags_out
);

    localparam int RB = pp2p_pkg::ROOT_BITS;
    localparam int ZW = pp2p_pkg::ANGLE_BITS;
    localparam int BIT_POS = RB - 2 - 2 * STEP;
    localparam logic [RB-1:0] ROOT_BIT = {{(RB - 1){1'b0}}, 1'b1} << BIT_POS;

    logic valid_reg;
    logic signed [XW-1:0] x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0] z_reg, z_next;
    logic [RB-1:0] rem_reg, res_reg, rem_next, res_next, trial;
    pp2p_pkg::flags_t flags_reg;
    logic take;

    assign ready_out = !valid_reg || ready_in;

    // one restoring square root digit
    always_comb
    begin
        trial    = res_in + ROOT_BIT;
        take     = (rem_in >= trial);
        rem_next = take ? (rem_in - trial) : rem_in;
        res_next = take ? ((res_in >> 1) + ROOT_BIT) : (res_in >> 1);
    end

    generate
        if (STEP < ROTATION_STEPS)
        begin : g_rot
            logic signed [XW-1:0] xs, ys;
            logic signed [ZW-1:0] atan_s;
            always_comb
            begin
                xs     = x_in >>> STEP;
                ys     = y_in >>> STEP;
                atan_s = $signed({1'b0, pp2p_pkg::atan_q24(5'(STEP))});
                if (!y_in[XW-1])
                begin
                    x_next = x_in + ys;
                    y_next = y_in - xs;
                    z_next = z_in + atan_s;
                end
                else
                begin
                    x_next = x_in - ys;
                    y_next = y_in + xs;
                    z_next = z_in - atan_s;
                end
            end
        end
        else
        begin : g_hold
            assign x_next = x_in;
            assign y_next = y_in;
            assign z_next = z_in;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            rem_reg   <= rem_next;
            res_reg   <= res_next;
            flags_reg <= flags_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign z_out     = z_reg;
    assign rem_out   = rem_reg;
    assign res_out   = res_reg;
    assign flags_out = flags_reg;

    a_takes_item: assert property (@(posedge clk) disable iff (!rst_n)
        valid_in && ready_out |=> valid_reg)
        else $error("cell dropped an item offered while it was free");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !ready_in |=> valid_reg && $stable(res_reg) && $stable(rem_reg)
            && $stable(z_reg))
        else $error("cell changed a stalled item");

    a_x_positive: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !flags_reg.special |-> !x_reg[XW-1])
        else $error("rotation x went negative");

endmodule

FILE: design/pp2p_finish.sv
module pp2p_finish (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   valid_in,
    output logic                                   ready_out,
    input  logic signed [pp2p_pkg::ANGLE_BITS-1:0] z_in,
    input  logic [pp2p_pkg::ROOT_BITS-1:0]         rem_in,
    input  logic [pp2p_pkg::ROOT_BITS-1:0]         res_in,
    input  pp2p_pkg::flags_t                       flags_in,
    output logic                                   valid_out,
    input  logic                                   ready_in,
    output logic [pp2p_pkg::BEARING_BITS-1:0]      bearing,
    output logic [pp2p_pkg::SEP_BITS-1:0]          separation
);

    localparam int ZW = pp2p_pkg::ANGLE_BITS;
    localparam int TW = ZW - pp2p_pkg::ROUND_SHIFT;
    localparam int SB = pp2p_pkg::SEP_BITS;
    localparam int BB = pp2p_pkg::BEARING_BITS;
    localparam logic signed [TW-1:0] PI_T     = TW'(pp2p_pkg::PI_Q13);
    localparam logic signed [TW-1:0] NEG_PI_T = TW'(-pp2p_pkg::PI_Q13);

    logic valid_reg;
    logic [pp2p_pkg::BEARING_BITS-1:0] bearing_reg, bearing_next;
    logic [SB-1:0] sep_reg, sep_next;
    logic signed [ZW-1:0] zr;
    logic signed [TW-1:0] t;
    logic inc, sat;

    assign ready_out = !valid_reg || ready_in;

    always_comb
    begin
        zr = z_in + ZW'(pp2p_pkg::ROUND_HALF);
        t  = $signed(zr[ZW-1:pp2p_pkg::ROUND_SHIFT]);
        if (flags_in.special)
            bearing_next = flags_in.special_bearing;
        else if ((t <= NEG_PI_T) || (t > PI_T))
            bearing_next = BB'(pp2p_pkg::PI_Q13);
        else
            bearing_next = t[pp2p_pkg::BEARING_BITS-1:0];

        // round to nearest: remainder above the root means the upper integer is closer
        inc = (rem_in > res_in);
        sat = flags_in.big || res_in[SB]
            || ((res_in[SB-1:0] == pp2p_pkg::SEP_MAX) && inc);
        sep_next = sat ? pp2p_pkg::SEP_MAX : (res_in[SB-1:0] + SB'(inc));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (ready_out)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (ready_out)
        begin
            bearing_reg <= bearing_next;
            sep_reg     <= sep_next;
        end
    end

    assign valid_out  = valid_reg;
    assign bearing    = bearing_reg;
    assign separation = sep_reg;

endmodule

FILE: design/point_pair_to_polar.sv
// 4 setup stages, 26 cells and an output reg; each cell does one root digit
// the first ROTATION_STEPS cells also rotate; throughput: one item per cycle while m_tready is high
// a stage holds its item only while the stage after it is full and stalled
// reset: rst_n low clears every stage valid flag at once; data registers are not reset
module point_pair_to_polar #(
    parameter int COORD_BITS     = 24,
    parameter int ROTATION_STEPS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [((4 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata, // from_x, from_y, to_x, to_y
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [pp2p_pkg::OUT_BITS-1:0]              m_tdata  // bearing, separation
);

    localparam int XW = COORD_BITS + pp2p_pkg::GUARD_BITS + 3;
    localparam int NC = pp2p_pkg::ROOT_STEPS;
    localparam int ZW = pp2p_pkg::ANGLE_BITS;
    localparam int RB = pp2p_pkg::ROOT_BITS;

    logic signed [COORD_BITS-1:0] from_x, from_y, to_x, to_y;

    logic                 valid_c [0:NC];
    logic                 ready_c [0:NC];
    logic signed [XW-1:0] x_c     [0:NC];
    logic signed [XW-1:0] y_c     [0:NC];
    logic signed [ZW-1:0] z_c     [0:NC];
    logic [RB-1:0]        rem_c   [0:NC];
    logic [RB-1:0]        res_c   [0:NC];
    pp2p_pkg::flags_t     flags_c [0:NC];

    logic [pp2p_pkg::BEARING_BITS-1:0] bearing;
    logic [pp2p_pkg::SEP_BITS-1:0]     separation;

    assign from_x = s_tdata[COORD_BITS-1:0];
    assign from_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign to_x   = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign to_y   = s_tdata[4*COORD_BITS-1:3*COORD_BITS];

    pp2p_prep #(
        .COORD_BITS(COORD_BITS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (s_tvalid),
        .ready_out (s_tready),
        .from_x    (from_x),
        .from_y    (from_y),
        .to_x      (to_x),
        .to_y      (to_y),
        .valid_out (valid_c[0]),
        .ready_in  (ready_c[0]),
        .x_out     (x_c[0]),
        .y_out     (y_c[0]),
        .z_out     (z_c[0]),
        .n_out     (rem_c[0]),
        .flags_out (flags_c[0])
    );

    assign res_c[0] = '0;

    generate
        for (genvar k = 0; k < NC; k++)
        begin : g_cell
            pp2p_cell #(
                .XW             (XW),
                .STEP           (k),
                .ROTATION_STEPS (ROTATION_STEPS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .valid_in  (valid_c[k]),
                .ready_out (ready_c[k]),
                .x_in      (x_c[k]),
                .y_in      (y_c[k]),
                .z_in      (z_c[k]),
                .rem_in    (rem_c[k]),
                .res_in    (res_c[k]),
                .flags_in  (flags_c[k]),
                .valid_out (valid_c[k+1]),
                .ready_in  (ready_c[k+1]),
                .x_out     (x_c[k+1]),
                .y_out     (y_c[k+1]),
                .z_out     (z_c[k+1]),
                .rem_out   (rem_c[k+1]),
                .res_out   (res_c[k+1]),
                .flags_out (flags_c[k+1])
            );
        end
    endgenerate

    pp2p_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid_in   (valid_c[NC]),
        .ready_out  (ready_c[NC]),
        .z_in       (z_c[NC]),
        .rem_in     (rem_c[NC]),
        .res_in     (res_c[NC]),
        .flags_in   (flags_c[NC]),
        .valid_out  (m_tvalid),
        .ready_in   (m_tready),
        .bearing    (bearing),
        .separation (separation)
    );

    assign m_tdata = {{(pp2p_pkg::OUT_BITS - pp2p_pkg::SEP_BITS - pp2p_pkg::BEARING_BITS){1'b0}},
                      separation, bearing};

endmodule

FILE: dv/point_pair_to_polar_tb.sv
`timescale 1ns / 1ps

module point_pair_to_polar_tb;

    localparam int COORD_BITS     = 24;
    localparam int ROTATION_STEPS = 16;
    localparam int DATA_BITS      = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 300;

    localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t from_x;
        coord_t from_y;
        coord_t to_x;
        coord_t to_y;
    } point_pair_t;

    typedef struct packed {
        logic [pp2p_pkg::BEARING_BITS-1:0] bearing;
        logic [pp2p_pkg::SEP_BITS-1:0]     separation;
    } polar_t;

    logic                          clk;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [DATA_BITS-1:0]          s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [pp2p_pkg::OUT_BITS-1:0] m_tdata;

    polar_t pending_polar[$];
    int     error_count    = 0;
    bit     idle_enable    = 1'b1;
    int     hold_requests  = 0;

    longint rotation_angle_q24 [0:23] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    point_pair_to_polar #(
        .COORD_BITS     (COORD_BITS),
        .ROTATION_STEPS (ROTATION_STEPS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // cordic vectoring with half-plane pre-rotation, rounded to q13
    function automatic longint predict_bearing(longint dx, longint dy);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        if (dx == 0)
        begin
            if (dy > 0)
                return pp2p_pkg::HALF_PI_Q13;
            if (dy < 0)
                return -pp2p_pkg::HALF_PI_Q13;
            return 0;
        end
        if (dy == 0)
            return (dx > 0) ? 0 : pp2p_pkg::PI_Q13;
        if (dx > 0)
        begin
            x = dx;
            y = dy;
            z = 0;
        end
        else
        begin
            x = -dx;
            y = -dy;
            z = (dy > 0) ? longint'(pp2p_pkg::PI_Q24) : -longint'(pp2p_pkg::PI_Q24);
        end
        x = x <<< pp2p_pkg::GUARD_BITS;
        y = y <<< pp2p_pkg::GUARD_BITS;
        for (int i = 0; i < ROTATION_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + rotation_angle_q24[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - rotation_angle_q24[i];
            end
        end
        t = (z + pp2p_pkg::ROUND_HALF) >>> pp2p_pkg::ROUND_SHIFT;
        if (t <= -pp2p_pkg::PI_Q13)
            t = pp2p_pkg::PI_Q13;
        if (t > pp2p_pkg::PI_Q13)
            t = pp2p_pkg::PI_Q13;
        return t;
    endfunction

    // digit-by-digit square root, then round to nearest
    function automatic longint unsigned rounded_distance(longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'h1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= root + b)
            begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        if (n > root)
            root = root + 1;
        return root;
    endfunction

    function automatic polar_t predict_polar(point_pair_t p);
        longint          dx;
        longint          dy;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned sep;
        longint          b;
        polar_t          r;
        dx = longint'(p.to_x) - longint'(p.from_x);
        dy = longint'(p.to_y) - longint'(p.from_y);
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > pp2p_pkg::SEP_MAX || ay > pp2p_pkg::SEP_MAX)
            sep = pp2p_pkg::SEP_MAX;
        else
        begin
            sep = rounded_distance(ax * ax + ay * ay);
            if (sep > pp2p_pkg::SEP_MAX)
                sep = pp2p_pkg::SEP_MAX;
        end
        b = predict_bearing(dx, dy);
        r.bearing    = b[pp2p_pkg::BEARING_BITS-1:0];
        r.separation = sep[pp2p_pkg::SEP_BITS-1:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_enable || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_pair(point_pair_t p);
        int gap;
        s_tdata  <= {p.to_y, p.to_x, p.from_y, p.from_x};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pending_polar.push_back(predict_polar(p));
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_coords(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
        point_pair_t p;
        p.from_x = fx;
        p.from_y = fy;
        p.to_x   = tx;
        p.to_y   = ty;
        send_pair(p);
    endtask

    task automatic drain();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (pending_polar.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_reset();
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_special_cases();
        // same point, start at origin too
        send_coords(0, 0, 0, 0);
        send_coords(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN);
        // vertical and horizontal differences
        send_coords(5, 7, 5, 100);
        send_coords(-3, 9, -3, -4000);
        send_coords(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
        send_coords(10, -2, 20000, -2);
        send_coords(10, -2, -9, -2);
        send_coords(COORD_MAX, 0, COORD_MIN, 0);
        // bearing close to minus pi wraps to plus pi
        send_coords(0, 0, -COORD_MAX, -1);
        send_coords(0, 0, -COORD_MAX, 1);
        send_coords(COORD_MAX, 1, COORD_MIN, 0);
        send_coords(0, 0, -100000, -1);
        // extremes of the difference
        send_coords(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_coords(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        send_coords(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_coords(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        // single vector and diagonals
        send_coords(0, 0, 3, 4);
        send_coords(0, 0, -1, 1);
        send_coords(0, 0, 1, -1);
        send_coords(0, 0, -1, -1);
        send_coords(-1, -1, 0, 0);
        send_coords(0, 0, 1, 1);
        drain();
    endtask

    function automatic coord_t offset_coord(coord_t base, int span);
        int d;
        d = int'($urandom_range(0, 2 * span)) - span;
        return coord_t'(int'(base) + d);
    endfunction

    function automatic point_pair_t random_pair();
        point_pair_t p;
        int          span;
        p = {$urandom(), $urandom(), $urandom()};
        case ($urandom_range(0, 9)) inside
            5, 6:
            begin
                case ($urandom_range(0, 2))
                    0:       span = 2;
                    1:       span = 100;
                    default: span = 50000;
                endcase
                p.to_x = offset_coord(p.from_x, span);
                p.to_y = offset_coord(p.from_y, span);
            end
            7:
            begin
                if ($urandom_range(0, 1))
                    p.to_x = p.from_x;
                else
                    p.to_y = p.from_y;
            end
            8:
            begin
                p.from_x = '0;
                p.from_y = '0;
            end
            9:
            begin
                p.from_x = COORD_MAX - coord_t'($urandom_range(0, 15));
                p.to_x   = COORD_MIN + coord_t'($urandom_range(0, 15));
                p.to_y   = offset_coord(p.from_y, 3);
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic test_random_pairs(int count);
        repeat (count) send_pair(random_pair());
        drain();
    endtask

    task automatic test_back_to_back(int count);
        idle_enable = 1'b0;
        repeat (count) send_pair(random_pair());
        drain();
        idle_enable = 1'b1;
    endtask

    task automatic test_output_hold(int count);
        idle_enable = 1'b0;
        hold_requests = hold_requests + 1;
        repeat (count) send_pair(random_pair());
        drain();
        idle_enable = 1'b1;
    endtask

    // receiver: random stalls, plus a long hold when asked
    initial
    begin
        int hold_left;
        int stall_left;
        int holds_served;
        hold_left    = 0;
        stall_left   = 0;
        holds_served = 0;
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                m_tready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 99) < 15)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        polar_t want;
        polar_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.bearing    = m_tdata[pp2p_pkg::BEARING_BITS-1:0];
            got.separation = m_tdata[pp2p_pkg::BEARING_BITS +: pp2p_pkg::SEP_BITS];
            if (pending_polar.size() == 0)
            begin
                $display("%0t: unexpected item bearing %0d separation %0d",
                         $time, $signed(got.bearing), got.separation);
                error_count = error_count + 1;
            end
            else
            begin
                want = pending_polar.pop_front();
                if (got.bearing !== want.bearing)
                begin
                    $display("%0t: bearing expected %0d actual %0d",
                             $time, $signed(want.bearing), $signed(got.bearing));
                    error_count = error_count + 1;
                end
                if (got.separation !== want.separation)
                begin
                    $display("%0t: separation expected %0d actual %0d",
                             $time, want.separation, got.separation);
                    error_count = error_count + 1;
                end
            end
        end
    end

    initial
    begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("point_pair_to_polar_tb: done, errors");
        $finish;
    end

    initial
    begin
        apply_reset();
        test_special_cases();
        test_random_pairs(480);
        test_back_to_back(100);
        test_output_hold(100);
        test_random_pairs(20);
        if (error_count == 0)
            $display("point_pair_to_polar_tb: done, clean");
        else
            $display("point_pair_to_polar_tb: done, errors");
        $finish;
    end

endmodule
